// ===== hdl/bsc_pkg.sv =====
package bsc_pkg;

  localparam int NumRegs = 8;
  localparam int AddrW = 5;
  localparam int DivStages = 32;

  // register indexes
  localparam logic [2:0] RegAc1 = 3'd0;
  localparam logic [2:0] RegAc2 = 3'd1;
  localparam logic [2:0] RegAc3 = 3'd2;
  localparam logic [2:0] RegAc4 = 3'd3;
  localparam logic [2:0] RegAc5Ac6 = 3'd4;
  localparam logic [2:0] RegB1 = 3'd5;
  localparam logic [2:0] RegB2 = 3'd6;
  localparam logic [2:0] RegMcMd = 3'd7;

  typedef struct packed {
    logic [15:0] temp_word;
    logic [18:0] press_word;
    logic [1:0]  oversampling;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] temp_decidegrees;
    logic signed [31:0] press_pascal;
    logic               div_error;
  } result_t;

  typedef struct packed {
    logic [15:0] ac1;
    logic [15:0] ac2;
    logic [15:0] ac3;
    logic [15:0] ac4;
    logic [15:0] ac5;
    logic [15:0] ac6;
    logic [15:0] b1;
    logic [15:0] b2;
    logic [15:0] mc;
    logic [15:0] md;
  } calib_t;

  // sign extension of a 16-bit coefficient to a 32-bit word
  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  // arithmetic shift right of a 32-bit word
  function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned n);
    asr32 = 32'($signed(v) >>> n);
  endfunction

endpackage

// ===== hdl/bsc_stream_if.sv =====
interface bsc_stream_if #(
  parameter int W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== hdl/baro_sensor_compensation_core.sv =====
// barometric sensor compensation core
// input channel in: one transfer carries temp_word, press_word and
// oversampling; output channel out: one transfer per input item carrying
// temp_decidegrees, press_pascal and div_error (results zero when set).
// calibration coefficients are written over the apb port at 4*index; the
// user writes them only while no item is in flight; it is not enforced.
// path: input transfer to output transfer runs through two 32-stage
// dividers and the multiply stages around them.
// throughput: one item per cycle while out is not stalled; the whole
// pipeline advances together. when out is stalled with a valid result
// the pipeline holds and in.ready drops, so nothing is lost or repeated;
// in.ready stays high while the output stage is empty or being taken.
// reset (rst, synchronous) clears all valid bits and the coefficients.
module baro_sensor_compensation_core (
  input  logic                      clk,
  input  logic                      rst,
  bsc_stream_if.sink                in,
  bsc_stream_if.source              out,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [bsc_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import bsc_pkg::*;

  calib_t  calib;
  logic    en;
  sample_t smp;
  result_t res;

  bsc_cfg_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .calib(calib)
  );

  // pipeline advances unless the output holds an untaken result
  assign en       = !out.valid || out.ready;
  assign in.ready = en;
  assign smp      = in.data;

  bsc_datapath u_dp (
    .clk(clk), .rst(rst), .en(en), .calib(calib),
    .in_valid(in.valid && en), .in_data(smp),
    .out_valid(out.valid), .out_data(res)
  );
  assign out.data = res;

  // a stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |=> out.valid && $stable(out.data))
    else $error("result changed under stall");
  // zero results on divide error
  a_err: assert property (@(posedge clk) disable iff (rst)
    out.valid && res.div_error |-> res.press_pascal == 0 && res.temp_decidegrees == 0)
    else $error("nonzero result with error");
  // input is refused only while output is stalled
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !in.ready |-> out.valid && !out.ready)
    else $error("ready dropped without stall");
endmodule

// ===== hdl/bsc_udiv.sv =====
// pipelined restoring unsigned divider, one quotient bit per stage,
// with side data traveling alongside each stage
module bsc_udiv #(
  parameter int SideW = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [31:0]      in_num,
  input  logic [31:0]      in_den,
  input  logic [SideW-1:0] in_side,
  output logic             out_valid,
  output logic [31:0]      out_quot,
  output logic [SideW-1:0] out_side
);
  import bsc_pkg::*;

  logic [DivStages:0]       vld;
  logic [31:0]              rem  [DivStages+1];
  logic [31:0]              quo  [DivStages+1];
  logic [31:0]              den  [DivStages+1];
  logic [SideW-1:0]         side [DivStages+1];

  assign vld[0]  = in_valid;
  assign rem[0]  = '0;
  assign quo[0]  = in_num;
  assign den[0]  = in_den;
  assign side[0] = in_side;

  // each stage shifts in one dividend bit and tries a subtract
  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic [32:0] trial;
    logic [32:0] diff;
    always_comb begin
      trial = {rem[s], quo[s][31]};
      diff  = trial - {1'b0, den[s]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
      if (en) begin
        if (diff[32]) begin
          rem[s+1] <= trial[31:0];
          quo[s+1] <= {quo[s][30:0], 1'b0};
        end else begin
          rem[s+1] <= diff[31:0];
          quo[s+1] <= {quo[s][30:0], 1'b1};
        end
        den[s+1]  <= den[s];
        side[s+1] <= side[s];
      end
    end
  end

  assign out_valid = vld[DivStages];
  assign out_quot  = quo[DivStages];
  assign out_side  = side[DivStages];
endmodule

// ===== hdl/bsc_cfg_regs.sv =====
// apb register file for calibration coefficients
module bsc_cfg_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [bsc_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output bsc_pkg::calib_t           calib
);
  import bsc_pkg::*;

  logic [31:0] regs [NumRegs];
  logic [2:0]  idx;

  assign idx    = paddr[AddrW-1:2];
  assign pready = 1'b1;

  // write on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) regs[i] <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        RegAc5Ac6, RegMcMd: regs[idx] <= pwdata;
        default:            regs[idx] <= {16'd0, pwdata[15:0]};
      endcase
    end
  end

  assign prdata = (paddr[1:0] == 2'b00) ? regs[idx] : '0;

  always_comb begin
    calib.ac1 = regs[RegAc1][15:0];
    calib.ac2 = regs[RegAc2][15:0];
    calib.ac3 = regs[RegAc3][15:0];
    calib.ac4 = regs[RegAc4][15:0];
    calib.ac5 = regs[RegAc5Ac6][31:16];
    calib.ac6 = regs[RegAc5Ac6][15:0];
    calib.b1  = regs[RegB1][15:0];
    calib.b2  = regs[RegB2][15:0];
    calib.mc  = regs[RegMcMd][31:16];
    calib.md  = regs[RegMcMd][15:0];
  end
endmodule

// ===== hdl/bsc_datapath.sv =====
// compensation pipeline: temperature stages, temperature divider,
// pressure stages, pressure divider, final polynomial stages
module bsc_datapath (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  bsc_pkg::calib_t  calib,
  input  logic             in_valid,
  input  bsc_pkg::sample_t in_data,
  output logic             out_valid,
  output bsc_pkg::result_t out_data
);
  import bsc_pkg::*;

  // ---------------- stage a: x1 product
  logic        a_v;
  logic [31:0] a_prod;
  logic [18:0] a_up;
  logic [1:0]  a_oss;
  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else if (en) a_v <= in_valid;
    if (en) begin
      a_prod <= ({16'd0, in_data.temp_word} - {16'd0, calib.ac6}) * {16'd0, calib.ac5};
      a_up   <= in_data.press_word;
      a_oss  <= in_data.oversampling;
    end
  end

  // ---------------- stage b: den, signs, magnitudes for divide
  logic [31:0] b_x1_c, b_den_c, b_num_c;
  logic        b_v;
  logic [31:0] b_x1, b_mnum, b_mden;
  logic        b_neg, b_zero;
  logic [18:0] b_up;
  logic [1:0]  b_oss;
  always_comb begin
    b_x1_c  = asr32(a_prod, 15);
    b_den_c = b_x1_c + sx16(calib.md);
    b_num_c = sx16(calib.mc) << 11;
  end
  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else if (en) b_v <= a_v;
    if (en) begin
      b_x1   <= b_x1_c;
      b_mnum <= b_num_c[31] ? 32'd0 - b_num_c : b_num_c;
      b_mden <= b_den_c[31] ? 32'd0 - b_den_c : b_den_c;
      b_neg  <= b_num_c[31] ^ b_den_c[31];
      b_zero <= b_den_c == 32'd0;
      b_up   <= a_up;
      b_oss  <= a_oss;
    end
  end

  // ---------------- temperature divider
  localparam int TSideW = 32 + 1 + 1 + 19 + 2;
  logic              td_v;
  logic [31:0]       td_q;
  logic [TSideW-1:0] td_side;
  bsc_udiv #(.SideW(TSideW)) u_tdiv (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(b_v), .in_num(b_mnum), .in_den(b_mden),
    .in_side({b_x1, b_neg, b_zero, b_up, b_oss}),
    .out_valid(td_v), .out_quot(td_q), .out_side(td_side)
  );
  logic [31:0] td_x1;
  logic        td_neg, td_zero;
  logic [18:0] td_up;
  logic [1:0]  td_oss;
  assign {td_x1, td_neg, td_zero, td_up, td_oss} = td_side;

  // ---------------- stage c: b5, b6, temp
  logic        c_v, c_err;
  logic [31:0] c_b6;
  logic [15:0] c_temp;
  logic [18:0] c_up;
  logic [1:0]  c_oss;
  logic [31:0] c_b5, c_tw;
  always_comb begin
    c_b5 = td_x1 + (td_neg ? 32'd0 - td_q : td_q);
    c_tw = asr32(c_b5 + 32'd8, 4);
  end
  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0;
    else if (en) c_v <= td_v;
    if (en) begin
      c_err  <= td_zero;
      c_b6   <= c_b5 - 32'd4000;
      c_temp <= c_tw[15:0];
      c_up   <= td_up;
      c_oss  <= td_oss;
    end
  end

  // ---------------- stage d: products of b6
  logic        d_v, d_err;
  logic [31:0] d_sqp, d_ac2b6, d_ac3b6;
  logic [15:0] d_temp;
  logic [18:0] d_up;
  logic [1:0]  d_oss;
  always_ff @(posedge clk) begin
    if (rst) d_v <= 1'b0;
    else if (en) d_v <= c_v;
    if (en) begin
      d_err   <= c_err;
      d_sqp   <= c_b6 * c_b6;
      d_ac2b6 <= sx16(calib.ac2) * c_b6;
      d_ac3b6 <= sx16(calib.ac3) * c_b6;
      d_temp  <= c_temp;
      d_up    <= c_up;
      d_oss   <= c_oss;
    end
  end

  // ---------------- stage e: products of sq
  logic        e_v, e_err;
  logic [31:0] e_b2sq, e_b1sq, e_ac2b6, e_ac3b6;
  logic [15:0] e_temp;
  logic [18:0] e_up;
  logic [1:0]  e_oss;
  logic [31:0] e_sq;
  always_comb e_sq = asr32(d_sqp, 12);
  always_ff @(posedge clk) begin
    if (rst) e_v <= 1'b0;
    else if (en) e_v <= d_v;
    if (en) begin
      e_err   <= d_err;
      e_b2sq  <= sx16(calib.b2) * e_sq;
      e_b1sq  <= sx16(calib.b1) * e_sq;
      e_ac2b6 <= d_ac2b6;
      e_ac3b6 <= d_ac3b6;
      e_temp  <= d_temp;
      e_up    <= d_up;
      e_oss   <= d_oss;
    end
  end

  // ---------------- stage f: b3 and x3
  logic        f_v, f_err;
  logic [31:0] f_b3, f_x3;
  logic [15:0] f_temp;
  logic [18:0] f_up;
  logic [1:0]  f_oss;
  logic [31:0] f_x3a, f_b3c, f_x3c;
  always_comb begin
    f_x3a = asr32(e_b2sq, 11) + asr32(e_ac2b6, 11);
    f_b3c = asr32(((sx16(calib.ac1) * 32'd4 + f_x3a) << e_oss) + 32'd2, 2);
    f_x3c = asr32(asr32(e_ac3b6, 13) + asr32(e_b1sq, 16) + 32'd2, 2);
  end
  always_ff @(posedge clk) begin
    if (rst) f_v <= 1'b0;
    else if (en) f_v <= e_v;
    if (en) begin
      f_err  <= e_err;
      f_b3   <= f_b3c;
      f_x3   <= f_x3c;
      f_temp <= e_temp;
      f_up   <= e_up;
      f_oss  <= e_oss;
    end
  end

  // ---------------- stage g: b4 product and b7 difference
  logic        g_v, g_err;
  logic [31:0] g_b4p;
  logic [31:0] g_diff;
  logic [15:0] g_temp;
  logic [1:0]  g_oss;
  always_ff @(posedge clk) begin
    if (rst) g_v <= 1'b0;
    else if (en) g_v <= f_v;
    if (en) begin
      g_err  <= f_err;
      g_b4p  <= {16'd0, calib.ac4} * (f_x3 + 32'd32768);
      g_diff <= {13'd0, f_up} - f_b3;
      g_temp <= f_temp;
      g_oss  <= f_oss;
    end
  end

  // ---------------- stage h: b4, b7
  logic        h_v, h_err;
  logic [31:0] h_b4, h_b7;
  logic [15:0] h_temp;
  logic [31:0] h_b4c;
  // logical shift of the wrapped 32-bit product
  always_comb h_b4c = {15'd0, g_b4p[31:15]};
  always_ff @(posedge clk) begin
    if (rst) h_v <= 1'b0;
    else if (en) h_v <= g_v;
    if (en) begin
      h_err  <= g_err || h_b4c == 32'd0;
      h_b4   <= h_b4c;
      h_b7   <= g_diff * (32'd50000 >> g_oss);
      h_temp <= g_temp;
    end
  end

  // ---------------- pressure divider
  localparam int PSideW = 1 + 1 + 16;
  logic              pd_v;
  logic [31:0]       pd_q;
  logic [PSideW-1:0] pd_side;
  bsc_udiv #(.SideW(PSideW)) u_pdiv (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(h_v), .in_num(h_b7[31] ? h_b7 : h_b7 << 1), .in_den(h_b4),
    .in_side({h_err, h_b7[31], h_temp}),
    .out_valid(pd_v), .out_quot(pd_q), .out_side(pd_side)
  );
  logic        pd_err, pd_big;
  logic [15:0] pd_temp;
  assign {pd_err, pd_big, pd_temp} = pd_side;

  // ---------------- stage i: p and p>>8 square
  logic        i_v, i_err;
  logic [31:0] i_p, i_sq, i_m;
  logic [15:0] i_temp;
  logic [31:0] i_pc, i_ps;
  always_comb begin
    i_pc = pd_big ? pd_q << 1 : pd_q;
    i_ps = asr32(i_pc, 8);
  end
  always_ff @(posedge clk) begin
    if (rst) i_v <= 1'b0;
    else if (en) i_v <= pd_v;
    if (en) begin
      i_err  <= pd_err;
      i_p    <= i_pc;
      i_sq   <= i_ps * i_ps;
      i_m    <= (32'd0 - 32'd7357) * i_pc;
      i_temp <= pd_temp;
    end
  end

  // ---------------- stage j: times 3038
  logic        j_v, j_err;
  logic [31:0] j_p, j_x1p, j_m;
  logic [15:0] j_temp;
  always_ff @(posedge clk) begin
    if (rst) j_v <= 1'b0;
    else if (en) j_v <= i_v;
    if (en) begin
      j_err  <= i_err;
      j_p    <= i_p;
      j_x1p  <= i_sq * 32'd3038;
      j_m    <= i_m;
      j_temp <= i_temp;
    end
  end

  // ---------------- stage k: final sum
  logic [31:0] k_p;
  always_comb
    k_p = j_p + asr32(asr32(j_x1p, 16) + asr32(j_m, 16) + 32'd3791, 4);
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= j_v;
    if (en) begin
      out_data.div_error        <= j_err;
      out_data.press_pascal     <= j_err ? 32'sd0 : $signed(k_p);
      out_data.temp_decidegrees <= j_err ? 16'sd0 : $signed(j_temp);
    end
  end
endmodule

// ===== test/bsc_checker.sv =====
`timescale 1ns / 1ps
module bsc_checker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  bsc_pkg::sample_t       in_data,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  bsc_pkg::result_t       out_data,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [bsc_pkg::AddrW-1:0] paddr,
  input  logic [31:0]            pwdata,
  output int                     fail_count,
  output int                     pending
);
  import bsc_pkg::*;

  logic [31:0] coeff [NumRegs];
  result_t compensated_q[$];
  int mismatches;

  // signed 32-bit quotient, truncating toward zero
  function automatic logic [31:0] quot_s(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    quot_s = (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic logic [31:0] sar(input logic [31:0] v, input int n);
    sar = v[31] ? ~((~v) >> n) : (v >> n);
  endfunction

  function automatic logic [31:0] ext16(input logic [15:0] v);
    ext16 = {{16{v[15]}}, v};
  endfunction

  // compensation of one raw sample pair
  function automatic result_t compensate(input sample_t s);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] ut, up, x1, x2, x3, b5, b6, sq, b3, b4, b7, p, den, tmp;
    result_t r;
    ac1 = ext16(coeff[RegAc1][15:0]);
    ac2 = ext16(coeff[RegAc2][15:0]);
    ac3 = ext16(coeff[RegAc3][15:0]);
    ac4 = {16'd0, coeff[RegAc4][15:0]};
    ac5 = {16'd0, coeff[RegAc5Ac6][31:16]};
    ac6 = {16'd0, coeff[RegAc5Ac6][15:0]};
    b1 = ext16(coeff[RegB1][15:0]);
    b2 = ext16(coeff[RegB2][15:0]);
    mc = ext16(coeff[RegMcMd][31:16]);
    md = ext16(coeff[RegMcMd][15:0]);
    ut = {16'd0, s.temp_word};
    up = {13'd0, s.press_word};
    r = '0;
    r.div_error = 1'b1;
    x1 = sar((ut - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) return r;
    x2 = quot_s(mc << 11, den);
    b5 = x1 + x2;
    tmp = sar(b5 + 32'd8, 4);
    b6 = b5 - 32'd4000;
    sq = sar(b6 * b6, 12);
    x1 = sar(b2 * sq, 11);
    x2 = sar(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = sar(((ac1 * 32'd4 + x3) << s.oversampling) + 32'd2, 2);
    x1 = sar(ac3 * b6, 13);
    x2 = sar(b1 * sq, 16);
    x3 = sar(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + 32'd32768)) >> 15;
    if (b4 == 0) return r;
    b7 = (up - b3) * (32'd50000 >> s.oversampling);
    if (!b7[31]) p = (b7 * 32'd2) / b4;
    else p = (b7 / b4) * 32'd2;
    x1 = sar(p, 8) * sar(p, 8);
    x1 = sar(x1 * 32'd3038, 16);
    x2 = sar(-32'd7357 * p, 16);
    p = p + sar(x1 + x2 + 32'd3791, 4);
    r.temp_decidegrees = tmp[15:0];
    r.press_pascal = p;
    r.div_error = 1'b0;
    return r;
  endfunction

  assign fail_count = mismatches;
  assign pending = compensated_q.size();

  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) coeff[i] <= '0;
      compensated_q.delete();
      mismatches <= 0;
    end else begin
      // register write
      if (psel && penable && pwrite) begin
        if (paddr[4:2] == RegAc5Ac6 || paddr[4:2] == RegMcMd) coeff[paddr[4:2]] <= pwdata;
        else coeff[paddr[4:2]] <= {16'd0, pwdata[15:0]};
      end
      // input transfer
      if (in_valid && in_ready) compensated_q.push_back(compensate(in_data));
      // output transfer
      if (out_valid && out_ready) begin
        if (compensated_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result %h", out_data);
        end else begin
          exp_r = compensated_q.pop_front();
          if (exp_r !== out_data) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: exp t=%0d p=%0d e=%0b got t=%0d p=%0d e=%0b",
                exp_r.temp_decidegrees, exp_r.press_pascal, exp_r.div_error,
                out_data.temp_decidegrees, out_data.press_pascal, out_data.div_error);
          end
        end
      end
    end
  end
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import bsc_pkg::*;

  localparam int Latency = 75;
  localparam int StallLimit = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count, pending;
  int idle_cycles = 0;
  bit hold_off = 1'b0;

  bsc_stream_if #(.W($bits(sample_t))) in_ch ();
  bsc_stream_if #(.W($bits(result_t))) out_ch ();

  baro_sensor_compensation_core u_dut (
    .clk(clk), .rst(rst), .in(in_ch.sink), .out(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  bsc_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .pending(pending)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // receiver stall pattern, with one long hold-off on request
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else if (hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || pending == 0)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= AddrW'({idx, 2'b00}); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // wait until all results are back and the pipeline is empty
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
  endtask

  // send one sample, holding valid until the transfer happens
  task automatic send(input sample_t s);
    in_ch.valid <= 1'b1;
    in_ch.data <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic gap();
    in_ch.valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  task automatic rand_sample(output sample_t s);
    s.temp_word = 16'($urandom());
    s.press_word = 19'($urandom());
    s.oversampling = 2'($urandom_range(0, 3));
  endtask

  // typical device calibration with random spread
  task automatic calib_typical();
    reg_write(RegAc1, 32'd408 + $urandom_range(0, 8000));
    reg_write(RegAc2, -32'sd72 - $urandom_range(0, 1000));
    reg_write(RegAc3, -32'sd14383 + $urandom_range(0, 2000));
    reg_write(RegAc4, 32'd32741 + $urandom_range(0, 1000));
    reg_write(RegAc5Ac6, {16'd32757 - 16'($urandom_range(0, 9000)),
                          16'd23153 + 16'($urandom_range(0, 1000))});
    reg_write(RegB1, 32'd6190 + $urandom_range(0, 500));
    reg_write(RegB2, 32'd4 + $urandom_range(0, 60));
    reg_write(RegMcMd, {16'(-16'sd8711 + $signed(16'($urandom_range(0, 2000)))),
                        16'd2868 + 16'($urandom_range(0, 500))});
  endtask

  task automatic calib_random();
    for (int i = 0; i < NumRegs; i++) reg_write(3'(i), $urandom());
  endtask

  task automatic calib_fill(input logic [31:0] v);
    for (int i = 0; i < NumRegs; i++) reg_write(3'(i), v);
  endtask

  // random bursts of realistic samples and noise
  task automatic random_phase(input int n);
    sample_t s;
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && n > 0) begin
        rand_sample(s);
        if ($urandom_range(0, 3) != 0) begin
          s.temp_word = 16'd22000 + 16'($urandom_range(0, 12000));
          s.press_word = 19'd20000 + 19'($urandom_range(0, 300000));
        end
        send(s);
        burst--; n--;
      end
      if ($urandom_range(0, 3) != 0) gap();
    end
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    sample_t s;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // all coefficients zero: both divisors vanish
    s = '{16'd27898, 19'd23843, 2'd0};
    send(s);
    in_ch.valid <= 1'b0;
    drain();

    // datasheet example calibration
    reg_write(RegAc1, 32'd408);
    reg_write(RegAc2, -32'sd72);
    reg_write(RegAc3, -32'sd14383);
    reg_write(RegAc4, 32'd32741);
    reg_write(RegAc5Ac6, {16'd32757, 16'd23153});
    reg_write(RegB1, 32'd6190);
    reg_write(RegB2, 32'd4);
    reg_write(RegMcMd, {-16'sd8711, 16'd2868});
    send('{16'd27898, 19'd23843, 2'd0});
    send('{16'd0, 19'd0, 2'd0});
    send('{16'hFFFF, 19'h7FFFF, 2'd3});
    send('{16'h5555, 19'h2AAAA, 2'd1});
    send('{16'hAAAA, 19'h55555, 2'd2});
    for (int o = 0; o < 4; o++) send('{16'd27898, 19'd23843 << o, 2'(o)});
    in_ch.valid <= 1'b0;
    drain();

    // zero temperature divisor: ac5 zero and md zero
    reg_write(RegAc5Ac6, {16'd0, 16'd100});
    reg_write(RegMcMd, {16'd1, 16'd0});
    send('{16'd1234, 19'd5000, 2'd1});
    in_ch.valid <= 1'b0;
    drain();
    // zero pressure divisor: ac4 zero; also minimum/-1 style divide via mc
    reg_write(RegMcMd, {16'h8000, 16'hFFFF});
    reg_write(RegAc4, 32'd0);
    send('{16'd1234, 19'd5000, 2'd1});
    in_ch.valid <= 1'b0;
    drain();
    reg_write(RegAc4, 32'hFFFF);
    send('{16'd0, 19'h7FFFF, 2'd0});
    send('{16'hFFFF, 19'd0, 2'd3});
    in_ch.valid <= 1'b0;
    drain();

    // extremes: all ones, all zero, sign bits
    calib_fill(32'hFFFFFFFF);
    send('{16'hFFFF, 19'h7FFFF, 2'd3});
    send('{16'd0, 19'd0, 2'd0});
    in_ch.valid <= 1'b0;
    drain();
    calib_fill(32'h80008000);
    send('{16'h8000, 19'h40000, 2'd2});
    send('{16'h7FFF, 19'h3FFFF, 2'd1});
    in_ch.valid <= 1'b0;
    drain();

    // random phases under several calibrations
    calib_typical();
    random_phase(150);
    drain();

    // long output hold-off: pipeline fills and input stalls
    calib_typical();
    hold_off = 1'b1;
    fork
      random_phase(120);
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
    join
    drain();

    calib_random();
    random_phase(120);
    drain();
    calib_typical();
    random_phase(140);
    drain();
    calib_random();
    random_phase(100);
    drain();

    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
